// ===== src/deq_pkg.sv =====
// Package for the double-ended queue: sizes, opcode codes and controller states.
// Used by the double_ended_queue top level; depends on nothing.
package deq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 5;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_NOP        = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_LOAD
  } state_t;

endpackage

// ===== src/deq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Standalone; depends on no package.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== src/double_ended_queue.sv =====
// Bounded double-ended queue over a ring of entries held in a deq_ram instance.
// Depends on deq_pkg and deq_ram.
// Steps: accept, write, front/back read from the registered RAM ports, result
// load; the result is registered in the load step. A new item is accepted only
// in the idle step, after the last result is loaded; a held result stalls load.
// Reset (rst_n low, synchronous) empties the queue; entry storage is not cleared.
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] opcode, [34:3] entry_value, [39:35] zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] accepted, [32:1] front_value, [64:33] back_value, [69:65] entry_count,
  // [70] is_empty, [71] is_full
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import deq_pkg::*;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OPCODE_W-1:0]   op_r;
  logic [VALUE_W-1:0]    val_r;
  logic                  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                  q_full, q_empty;
  logic [IDX_W-1:0]      head_inc, head_dec, tail_slot, back_slot;
  logic [SUM_W-1:0]      tail_sum, back_sum;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata, front_rd, back_rd;
  logic [63:0]           val_ext, front_ext, back_ext;
  logic                  out_free;

  assign q_full   = (cnt_r == CNT_W'(DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(cnt_r);
  assign back_sum = tail_sum - 1'b1;
  assign tail_slot = IDX_W'((tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum);
  assign back_slot = IDX_W'((back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum);
  assign val_ext   = 64'(val_r);
  assign ram_wdata = val_ext[DATA_WIDTH-1:0];
  assign front_ext = 64'(front_rd);
  assign back_ext  = 64'(back_rd);
  assign out_free  = !out_valid_r || out_tready;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr_a (head_r),
    .rd_data_a (front_rd),
    .rd_addr_b (back_slot),
    .rd_data_b (back_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_READ;
      S_READ:  state_nxt = S_LOAD;
      S_LOAD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_slot;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = (state_r == S_IDLE);
    case (state_r)
      S_WRITE: begin
        case (op_r)
          OP_PUSH_FRONT: begin
            acc_nxt = !q_full;
            if (!q_full) begin
              head_nxt  = head_dec;
              cnt_nxt   = cnt_r + 1'b1;
              ram_we    = 1'b1;
              ram_waddr = head_dec;
            end
          end
          OP_PUSH_BACK: begin
            acc_nxt = !q_full;
            if (!q_full) begin
              cnt_nxt = cnt_r + 1'b1;
              ram_we  = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            acc_nxt = !q_empty;
            if (!q_empty) begin
              head_nxt = head_inc;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end
          OP_POP_BACK: begin
            acc_nxt = !q_empty;
            if (!q_empty) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          OP_NOP:  acc_nxt = 1'b1;
          default: acc_nxt = 1'b0;
        endcase
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {q_full, q_empty, COUNT_W'(cnt_r),
                           q_empty ? 32'd0 : back_ext[31:0],
                           q_empty ? 32'd0 : front_ext[31:0],
                           acc_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[OPCODE_W-1:0];
      val_r <= in_tdata[OPCODE_W+VALUE_W-1:OPCODE_W];
    end
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && !acc_nxt) |=> ($stable(cnt_r) && $stable(head_r)))
    else $error("rejected operation changed queue state");

  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOAD))
    else $error("result raised outside load step");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WRITE))
    else $error("RAM written outside update step");

endmodule
